### rtl/core/ict_pkg.sv
package ict_pkg;

  localparam int CordicSteps = 17;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [15:0] RAD2DEG_Q10 = 16'd58671;
  localparam logic signed [15:0] DEG_LIMIT = 16'sd23040;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [1:0] MOUNT_Z_FWD_Y_UP = 2'd1;
  localparam logic [1:0] MOUNT_Z_FWD_X_UP = 2'd2;

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == -16'sd32768) r = 16'sd32767;
    else r = -v;
    return r;
  endfunction

  function automatic logic [16:0] atan_entry(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd51472;
      5'd1:  r = 17'd30386;
      5'd2:  r = 17'd16055;
      5'd3:  r = 17'd8150;
      5'd4:  r = 17'd4091;
      5'd5:  r = 17'd2047;
      5'd6:  r = 17'd1024;
      5'd7:  r = 17'd512;
      5'd8:  r = 17'd256;
      5'd9:  r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/ict_isqrt.sv
module ict_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] operand,
  output logic        done,
  output logic [15:0] root
);

  logic [32:0] rem;
  logic [32:0] acc;
  logic [30:0] bitv;
  logic [3:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = acc + {2'b0, bitv};
  assign root  = acc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, operand};
        acc  <= '0;
        bitv <= 31'h4000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + {2'b0, bitv};
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/ict_cordic.sv
module ict_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [17:0] y_in,
  input  logic signed [17:0] x_in,
  output logic               done,
  output logic signed [19:0] angle
);

  logic signed [33:0] x, y;
  logic signed [33:0] xs, ys;
  logic signed [33:0] x0, y0;
  logic [4:0]         i;
  logic               busy;
  logic signed [19:0] step_ang;

  assign x0 = 34'(x_in) <<< 14;
  assign y0 = 34'(y_in) <<< 14;
  assign xs = x >>> i;
  assign ys = y >>> i;
  assign step_ang = 20'(ict_pkg::atan_entry(i));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      i     <= '0;
      angle <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        i <= '0;
        if (x_in == 18'sd0 && y_in == 18'sd0) begin
          angle <= '0;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x <= y0;  y <= -x0; angle <= ict_pkg::HALF_PI_Q16;
            end else begin
              x <= -y0; y <= x0;  angle <= -ict_pkg::HALF_PI_Q16;
            end
          end else begin
            x <= x0; y <= y0; angle <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys; y <= y - xs; angle <= angle + step_ang;
        end else begin
          x <= x - ys; y <= y + xs; angle <= angle - step_ang;
        end
        i <= i + 5'd1;
        if (i == 5'(ict_pkg::CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/imu_complementary_tilt_filter.sv
// Complementary pitch/roll filter for one IMU sample per beat. A valid sample passes
// through the 16-step integer square root and two 17-step CORDIC atan2 passes on one
// shared rotator (an atan2 of a zero vector skips the rotation steps), then seven steps
// per axis on one shared 26x26 multiplier for the blend and the degree conversion; the
// seeding sample skips the blend arithmetic. An invalid sample goes straight to the
// output. s_tready is high only while no sample is in work; a finished result waits in
// the output register, so the next sample can be taken before it is read. Configuration
// writes belong to idle time.
module imu_complementary_tilt_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [0:0]  s_tuser,  // sample_valid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // pitch_angle, roll_angle, pitch_degrees,
                                // roll_degrees, pitch_rate, roll_rate
  output logic [0:0]  m_tuser,  // estimate_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ0  = 4'd1;
  localparam logic [3:0] S_SQ1  = 4'd2;
  localparam logic [3:0] S_RST  = 4'd3;
  localparam logic [3:0] S_RWT  = 4'd4;
  localparam logic [3:0] S_CST  = 4'd5;
  localparam logic [3:0] S_CWT  = 4'd6;
  localparam logic [3:0] S_BL0  = 4'd7;
  localparam logic [3:0] S_BL1  = 4'd8;
  localparam logic [3:0] S_BL2  = 4'd9;
  localparam logic [3:0] S_BL3  = 4'd10;
  localparam logic [3:0] S_BL4  = 4'd11;
  localparam logic [3:0] S_DEG0 = 4'd12;
  localparam logic [3:0] S_DEG1 = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]  state;
  logic [1:0]  mode;
  logic [15:0] alpha;
  logic [23:0] period;

  logic               item_valid, seeded, axis;
  logic signed [15:0] fwd, lft, upv;
  logic signed [15:0] rate_hold [2];
  logic signed [15:0] ang_hold [2];
  logic signed [15:0] deg_hold [2];
  logic signed [23:0] acc_ang [2];
  logic signed [23:0] store [2];
  logic [31:0]        sumsq;
  logic [15:0]        root;
  logic signed [25:0] pred;
  logic signed [51:0] prod, mix;

  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic signed [15:0] fwd_n, lft_n, up_n, gp_n, gr_n;
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;
  logic [16:0]        inv_alpha;
  logic signed [51:0] blend_rnd, deg_rnd;
  logic signed [24:0] ang_rnd;
  logic signed [24:0] cord_ang;
  logic signed [23:0] cord_sat, blend_sat;
  logic signed [15:0] deg_sat, ang_sat;
  logic signed [17:0] cord_y, cord_x;
  logic               root_done, cord_done;
  logic [15:0]        root_val;
  logic signed [19:0] cord_z;
  logic               s_acc, out_free;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 2'd0;
      alpha  <= 16'd64225;
      period <= 24'd83886;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        ict_pkg::REG_MODE:   mode   <= pwdata[1:0];
        ict_pkg::REG_ALPHA:  alpha  <= pwdata[15:0];
        ict_pkg::REG_PERIOD: period <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ict_pkg::REG_MODE:   prdata = {30'd0, mode};
      ict_pkg::REG_ALPHA:  prdata = {16'd0, alpha};
      ict_pkg::REG_PERIOD: prdata = {8'd0, period};
      default:             prdata = '0;
    endcase
  end

  assign ax = s_tdata[15:0];
  assign ay = s_tdata[31:16];
  assign az = s_tdata[47:32];
  assign gx = s_tdata[63:48];
  assign gy = s_tdata[79:64];
  assign gz = s_tdata[95:80];

  always_comb begin
    case (mode)
      ict_pkg::MOUNT_Z_FWD_Y_UP: begin
        fwd_n = az; lft_n = ax; up_n = ay; gp_n = gx; gr_n = gz;
      end
      ict_pkg::MOUNT_Z_FWD_X_UP: begin
        fwd_n = az; lft_n = ict_pkg::neg_sat(ay); up_n = ax;
        gp_n = ict_pkg::neg_sat(gy); gr_n = gz;
      end
      default: begin
        fwd_n = ax; lft_n = ay; up_n = az; gp_n = gy; gr_n = gx;
      end
    endcase
  end

  assign inv_alpha = 17'h10000 - {1'b0, alpha};

  always_comb begin
    case (state)
      S_SQ0:   begin mul_a = 26'(lft);            mul_b = 26'(lft); end
      S_SQ1:   begin mul_a = 26'(upv);            mul_b = 26'(upv); end
      S_BL0:   begin mul_a = 26'(rate_hold[axis]); mul_b = 26'(period); end
      S_BL2:   begin mul_a = pred;                mul_b = 26'(alpha); end
      S_BL3:   begin mul_a = 26'(acc_ang[axis]);  mul_b = 26'(inv_alpha); end
      S_DEG0:  begin mul_a = 26'(store[axis]);    mul_b = 26'(ict_pkg::RAD2DEG_Q10); end
      default: begin mul_a = '0;                  mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign cord_ang = {cord_z, 5'd0};
  assign cord_sat = (cord_ang > 25'sd8388607)  ? 24'sd8388607 :
                    (cord_ang < -25'sd8388608) ? -24'sd8388608 : cord_ang[23:0];

  assign blend_rnd = (mix + 52'sd32768) >>> 16;
  assign blend_sat = (blend_rnd > 52'sd8388607)  ? 24'sd8388607 :
                     (blend_rnd < -52'sd8388608) ? -24'sd8388608 : blend_rnd[23:0];

  assign deg_rnd = (prod + 52'sd8388608) >>> 24;
  assign deg_sat = (deg_rnd > 52'(ict_pkg::DEG_LIMIT))  ? ict_pkg::DEG_LIMIT :
                   (deg_rnd < -52'(ict_pkg::DEG_LIMIT)) ? -ict_pkg::DEG_LIMIT :
                   deg_rnd[15:0];

  assign ang_rnd = (25'(store[axis]) + 25'sd128) >>> 8;
  assign ang_sat = (ang_rnd > 25'sd32767) ? 16'sd32767 : ang_rnd[15:0];

  assign cord_y = axis ? 18'(lft) : 18'(ict_pkg::neg_sat(fwd));
  assign cord_x = axis ? 18'(upv) : $signed({2'b00, root});

  ict_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_RST),
    .operand (sumsq),
    .done    (root_done),
    .root    (root_val)
  );

  ict_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CST),
    .y_in  (cord_y),
    .x_in  (cord_x),
    .done  (cord_done),
    .angle (cord_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      axis       <= 1'b0;
      seeded     <= 1'b0;
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tuser    <= '0;
      m_tdata    <= '0;
      for (int k = 0; k < 2; k++) begin
        store[k]     <= '0;
        rate_hold[k] <= '0;
        ang_hold[k]  <= '0;
        deg_hold[k]  <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            item_valid <= s_tuser[0];
            axis       <= 1'b0;
            if (s_tuser[0]) begin
              fwd <= fwd_n; lft <= lft_n; upv <= up_n;
              rate_hold[0] <= gp_n;
              rate_hold[1] <= gr_n;
              state <= S_SQ0;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SQ0: begin
          prod  <= mul_p;
          state <= S_SQ1;
        end
        S_SQ1: begin
          sumsq <= prod[31:0] + mul_p[31:0];
          state <= S_RST;
        end
        S_RST: state <= S_RWT;
        S_RWT: begin
          if (root_done) begin
            root  <= root_val;
            state <= S_CST;
          end
        end
        S_CST: state <= S_CWT;
        S_CWT: begin
          if (cord_done) begin
            acc_ang[axis] <= cord_sat;
            axis  <= ~axis;
            state <= axis ? S_BL0 : S_CST;
          end
        end
        S_BL0: begin
          if (!seeded) begin
            store[axis] <= acc_ang[axis];
            state       <= S_DEG0;
          end else begin
            prod  <= mul_p;
            state <= S_BL1;
          end
        end
        S_BL1: begin
          pred  <= 26'(store[axis]) + 26'((prod + 52'sd16384) >>> 15);
          state <= S_BL2;
        end
        S_BL2: begin
          prod  <= mul_p;
          state <= S_BL3;
        end
        S_BL3: begin
          mix   <= prod + mul_p;
          state <= S_BL4;
        end
        S_BL4: begin
          store[axis] <= blend_sat;
          state       <= S_DEG0;
        end
        S_DEG0: begin
          prod  <= mul_p;
          state <= S_DEG1;
        end
        S_DEG1: begin
          deg_hold[axis] <= deg_sat;
          ang_hold[axis] <= ang_sat;
          axis <= ~axis;
          if (axis) begin
            seeded <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_BL0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= item_valid;
            m_tdata  <= {rate_hold[1], rate_hold[0], deg_hold[1], deg_hold[0],
                         ang_hold[1], ang_hold[0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_seeded_sticks: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded) else $error("seeded flag dropped");

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_RWT) else $error("root done outside wait");

  a_cordic_in_wait: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> state == S_CWT) else $error("cordic done outside wait");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("result not posted");

endmodule

### test/imu_complementary_tilt_filter_test.sv
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_test;

  typedef struct packed {
    logic        ok;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] pitch_q97;
    logic [15:0] roll_q97;
    logic [15:0] pitch_rt;
    logic [15:0] roll_rt;
  } tilt_t;

  typedef struct {
    logic        valid;
    logic [15:0] ax, ay, az, gx, gy, gz;
    logic        known;
    tilt_t       want;
  } row_t;

  localparam int WatchLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  imu_complementary_tilt_filter i_dut (.*);

  always #2 clk = ~clk;

  logic [1:0]  mount;
  logic [15:0] alpha;
  logic [23:0] period;
  logic        seeded;
  logic signed [23:0] pitch_acc, roll_acc;
  logic signed [15:0] pitch_hold, roll_hold;

  tilt_t  pending_tilt[$];
  int     errors = 0;
  int     idle_cycles = 0;
  logic   recv_slow = 1'b0;

  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [63:0] clamp(logic signed [63:0] v,
                                                logic signed [63:0] lo,
                                                logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [15:0] negate(logic signed [15:0] v);
    return v == -16'sd32768 ? 16'sd32767 : -v;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 32;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] arctan2(logic signed [63:0] y,
                                                  logic signed [63:0] x);
    logic signed [63:0] z, t, xs, ys;
    logic signed [63:0] tab[17];
    tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
            128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 102944;
      end else begin
        t = x; x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += tab[i];
      end else begin
        x = x - ys; y = y + xs; z -= tab[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [23:0] mix_angle(logic signed [23:0] acc,
                                                  logic signed [15:0] rate,
                                                  logic signed [63:0] tilt);
    logic signed [63:0] pred, m;
    pred = 64'(acc) + round_shift(64'(rate) * $signed({40'd0, period}), 15);
    m = $signed({48'd0, alpha}) * pred + (64'sd65536 - $signed({48'd0, alpha})) * tilt;
    return 24'(clamp(round_shift(m, 16), -8388608, 8388607));
  endfunction

  function automatic tilt_t report(logic ok);
    tilt_t r;
    r.ok = ok;
    r.pitch = 16'(clamp(round_shift(64'(pitch_acc), 8), -32768, 32767));
    r.roll = 16'(clamp(round_shift(64'(roll_acc), 8), -32768, 32767));
    r.pitch_q97 = 16'(clamp(round_shift(64'(pitch_acc) * 58671, 24), -23040, 23040));
    r.roll_q97 = 16'(clamp(round_shift(64'(roll_acc) * 58671, 24), -23040, 23040));
    r.pitch_rt = pitch_hold;
    r.roll_rt = roll_hold;
    return r;
  endfunction

  function automatic tilt_t filter_sample(row_t s);
    logic signed [15:0] fwd, lft, up, gp, gr;
    logic signed [63:0] tp, tr, mag;
    if (s.valid) begin
      case (mount)
        ict_pkg::MOUNT_Z_FWD_Y_UP: begin
          fwd = s.az; lft = s.ax; up = s.ay; gp = s.gx; gr = s.gz;
        end
        ict_pkg::MOUNT_Z_FWD_X_UP: begin
          fwd = s.az; lft = negate(s.ay); up = s.ax; gp = negate(s.gy); gr = s.gz;
        end
        default: begin
          fwd = s.ax; lft = s.ay; up = s.az; gp = s.gy; gr = s.gx;
        end
      endcase
      pitch_hold = gp;
      roll_hold = gr;
      mag = $signed(root_floor(64'(64'(lft) * lft + 64'(up) * up)));
      tp = arctan2(64'(negate(fwd)), mag) * 32;
      tr = arctan2(64'(lft), 64'(up)) * 32;
      if (!seeded) begin
        pitch_acc = 24'(clamp(tp, -8388608, 8388607));
        roll_acc = 24'(clamp(tr, -8388608, 8388607));
        seeded = 1'b1;
      end else begin
        pitch_acc = mix_angle(pitch_acc, gp, tp);
        roll_acc = mix_angle(roll_acc, gr, tr);
      end
    end
    return report(s.valid);
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ict_pkg::REG_MODE:  mount = v[1:0];
      ict_pkg::REG_ALPHA: alpha = v[15:0];
      default:            period = v[23:0];
    endcase
  endtask

  task automatic send_sample(row_t s);
    tilt_t r;
    r = filter_sample(s);
    if (s.known && s.want !== r) begin
      errors++;
      if (errors <= 10) $display("directed row mismatch: typed %h predicted %h", s.want, r);
    end
    pending_tilt.push_back(r);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= s.valid;
    s_tdata <= {s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_tilt.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_gap;
    int g;
    g = $urandom_range(0, 9) == 0 ? $urandom_range(20, 150) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk);
  endtask

  function automatic logic [15:0] pick16;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1200)) - 600);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t mk(logic v, int ax, int ay, int az, int gx, int gy, int gz);
    row_t s;
    s.valid = v;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    s.known = 1'b0;
    s.want = '0;
    return s;
  endfunction

  always @(posedge clk) begin
    tilt_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("imu_complementary_tilt_filter_test: done, errors");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
               m_tdata[79:64], m_tdata[95:80]};
        if (pending_tilt.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h", got);
        end else begin
          want = pending_tilt.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) recv_slow <= ~recv_slow;
    if (recv_slow) m_tready <= $urandom_range(0, 9) == 0;
    else m_tready <= $urandom_range(0, 4) != 0;
  end

  initial begin
    row_t rows[$];
    row_t s;
    mount = 0; alpha = 16'd64225; period = 24'd83886;
    seeded = 0; pitch_acc = 0; roll_acc = 0; pitch_hold = 0; roll_hold = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    s = mk(0, 100, 200, 300, 5, 6, 7);
    s.known = 1'b1;
    s.want = '0;
    rows.push_back(s);
    rows.push_back(mk(1, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(1, 0, 0, 2511, 100, -100, 0));
    rows.push_back(mk(1, -32768, -32768, -32768, -32768, -32768, -32768));
    rows.push_back(mk(1, 32767, 32767, 32767, 32767, 32767, 32767));
    rows.push_back(mk(1, -32768, 0, -32768, 32767, -32768, 0));
    rows.push_back(mk(1, 0, 2511, -100, 0, 0, 0));
    rows.push_back(mk(1, 0, -2511, -100, 0, 0, 0));
    rows.push_back(mk(0, 1, 2, 3, 4, 5, 6));
    for (int i = 0; i < 6; i++) rows.push_back(mk(1, 0, 0, 100, 32767, 32767, 0));
    rows.push_back(mk(1, 1000, -1000, 2000, -32768, -32768, 1));
    foreach (rows[i]) send_sample(rows[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          reg_write(ict_pkg::REG_MODE, 1); reg_write(ict_pkg::REG_ALPHA, 0);
          reg_write(ict_pkg::REG_PERIOD, 0);
        end
        1: begin
          reg_write(ict_pkg::REG_MODE, 2); reg_write(ict_pkg::REG_ALPHA, 65535);
          reg_write(ict_pkg::REG_PERIOD, 24'hffffff);
        end
        2: reg_write(ict_pkg::REG_MODE, 3);
        3: begin
          reg_write(ict_pkg::REG_MODE, 0); reg_write(ict_pkg::REG_ALPHA, 64225);
          reg_write(ict_pkg::REG_PERIOD, 83886);
        end
        default: begin
          reg_write(ict_pkg::REG_MODE, $urandom_range(0, 3));
          reg_write(ict_pkg::REG_ALPHA, $urandom_range(0, 65535));
          reg_write(ict_pkg::REG_PERIOD, $urandom_range(0, 24'hffffff));
        end
      endcase
      if (ph == 1) begin
        send_sample(mk(1, -32768, 0, -32768, 0, -32768, 0));
        send_sample(mk(1, 0, -32768, 100, 0, 0, 0));
      end
      for (int n = 0; n < 200; n++) begin
        s = mk($urandom_range(0, 7) != 0, pick16(), pick16(), pick16(),
               pick16(), pick16(), pick16());
        if ($urandom_range(0, 1)) begin
          s.gx = 16'($urandom_range(0, 8000)) - 16'd4000;
          s.gy = 16'($urandom_range(0, 8000)) - 16'd4000;
          s.gz = 16'($urandom_range(0, 8000)) - 16'd4000;
        end
        random_gap();
        send_sample(s);
      end
      drain();
    end

    while (pending_tilt.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("imu_complementary_tilt_filter_test: done, clean");
    else $display("imu_complementary_tilt_filter_test: done, errors");
    $finish;
  end

endmodule
